// ===== rtl/core/ffpa_pkg.sv =====
package ffpa_pkg;

  // default pool geometry
  localparam int POOL_BYTES_DEF   = 128;
  localparam int HEADER_BYTES_DEF = 4;

  // fixed field widths
  localparam int REQ_W    = 8;
  localparam int OFFSET_W = 7;

  // walk outcome reported by the cell row
  typedef struct packed {
    logic                hit;
    logic                fail;
    logic [OFFSET_W-1:0] offset;
  } walk_status_t;

endpackage

// ===== rtl/core/ffpa_cell.sv =====
module ffpa_cell #(
  parameter int  POOL_BYTES   = ffpa_pkg::POOL_BYTES_DEF,
  parameter int  HEADER_BYTES = ffpa_pkg::HEADER_BYTES_DEF,
  parameter bit  FIRST        = 1'b0,
  localparam int SW           = $clog2(POOL_BYTES),
  localparam int OW           = $clog2(POOL_BYTES + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          split_any,
  input  logic                          left_pass,
  input  logic [ffpa_pkg::REQ_W-1:0]    left_want,
  input  logic [OW-1:0]                 left_off,
  input  logic                          left_valid,
  input  logic                          left_free,
  input  logic [SW-1:0]                 left_size,
  input  logic                          left_split,
  input  logic [SW-1:0]                 left_rest,
  output logic                          pass,
  output logic [ffpa_pkg::REQ_W-1:0]    pass_want,
  output logic [OW-1:0]                 pass_off,
  output logic                          valid,
  output logic                          free,
  output logic [SW-1:0]                 size,
  output logic                          split,
  output logic [SW-1:0]                 rest,
  output logic                          hit,
  output logic                          fail,
  output logic [ffpa_pkg::OFFSET_W-1:0] hit_offset
);

  localparam int EW = ((SW > ffpa_pkg::REQ_W) ? SW : ffpa_pkg::REQ_W) + 2;
  localparam int AW = OW + 4;
  localparam logic [EW-1:0] HDR_E = EW'(HEADER_BYTES);
  localparam logic [AW-1:0] HDR_A = AW'(HEADER_BYTES);
  localparam logic [SW-1:0] INIT_SIZE = SW'(POOL_BYTES - HEADER_BYTES);

  logic                       tok;
  logic [ffpa_pkg::REQ_W-1:0] want;
  logic [OW-1:0]              off;
  logic                       visited;

  logic [EW-1:0] size_e;
  logic [EW-1:0] want_e;
  logic [EW-1:0] rest_e;
  logic [AW-1:0] next_off;
  logic [AW-1:0] data_off;
  logic          fits;

  always_comb begin
    size_e   = EW'(size);
    want_e   = EW'(want);
    rest_e   = size_e - want_e - HDR_E;
    fits     = valid && free && (size_e >= want_e);
    hit      = tok && fits;
    split    = hit && (size_e > (want_e + HDR_E));
    rest     = rest_e[SW-1:0];
    fail     = tok && !valid;
    pass     = tok && valid && !fits;
    next_off = AW'(off) + AW'(size) + HDR_A;
    pass_off = next_off[OW-1:0];
    pass_want = want;
    data_off = AW'(off) + HDR_A;
    hit_offset = data_off[ffpa_pkg::OFFSET_W-1:0];
  end

  // token carries the request one cell per cycle
  always_ff @(posedge clk) begin
    want <= left_want;
    off  <= left_off;
    if (rst) begin
      tok     <= 1'b0;
      visited <= 1'b0;
    end else begin
      tok     <= left_pass;
      visited <= start ? 1'b0 : (visited | tok);
    end
  end

  // block record: take on a hit, shift right on an insertion upstream
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= FIRST;
      free  <= 1'b1;
      size  <= INIT_SIZE;
    end else if (hit) begin
      free <= 1'b0;
      if (split) begin
        size <= want_e[SW-1:0];
      end
    end else if (split_any && !visited && !tok) begin
      if (left_split) begin
        valid <= 1'b1;
        free  <= 1'b1;
        size  <= left_rest;
      end else begin
        valid <= left_valid;
        free  <= left_free;
        size  <= left_size;
      end
    end
  end

endmodule

// ===== rtl/core/ffpa_ctrl.sv =====
module ffpa_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ffpa_pkg::REQ_W-1:0]    request_size,
  output logic                          start,
  input  ffpa_pkg::walk_status_t        status,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          granted,
  output logic [ffpa_pkg::OFFSET_W-1:0] data_offset
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                    state;
  logic [1:0]                    state_next;
  logic                          res_grant;
  logic [ffpa_pkg::OFFSET_W-1:0] res_off;
  logic                          in_xfer;
  logic                          out_free;

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign start    = in_xfer && (request_size != '0);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = (request_size == '0) ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        if (status.hit || status.fail) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // hold the walk outcome until the output slot frees up
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      res_grant <= 1'b0;
      res_off   <= '0;
    end else if (state == ST_WALK && status.hit) begin
      res_grant <= 1'b1;
      res_off   <= status.offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      granted     <= res_grant;
      data_offset <= res_off;
    end
  end

endmodule

// ===== rtl/core/first_fit_pool_allocator.sv =====
// Timing: on transfer a request's token enters cell 0 and walks the cell row until a cell hits or fails;
// the outcome is held in ctrl and moves to the output register once the output slot is free.
// A zero-size request skips the walk and goes straight to a refused result.
// Throughput: one request at a time; the token walk over the cell row, one block per cycle,
// sets the pace. The next request is taken as soon as the result enters the output register.
// Reset (synchronous): cell 0 holds one free block spanning the pool, all other cells empty.
module first_fit_pool_allocator #(
  parameter int POOL_BYTES   = ffpa_pkg::POOL_BYTES_DEF,
  parameter int HEADER_BYTES = ffpa_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ffpa_pkg::REQ_W-1:0]    request_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          granted,
  output logic [ffpa_pkg::OFFSET_W-1:0] data_offset
);

  localparam int NCELL = POOL_BYTES / (HEADER_BYTES + 1);
  localparam int SW    = $clog2(POOL_BYTES);
  localparam int OW    = $clog2(POOL_BYTES + 1);

  logic                          start;
  logic                          split_any;
  ffpa_pkg::walk_status_t        status;

  logic                          c_pass   [NCELL];
  logic [ffpa_pkg::REQ_W-1:0]    c_want   [NCELL];
  logic [OW-1:0]                 c_off    [NCELL];
  logic                          c_valid  [NCELL];
  logic                          c_free   [NCELL];
  logic [SW-1:0]                 c_size   [NCELL];
  logic                          c_split  [NCELL];
  logic [SW-1:0]                 c_rest   [NCELL];
  logic                          c_hit    [NCELL];
  logic                          c_fail   [NCELL];
  logic [ffpa_pkg::OFFSET_W-1:0] c_hitoff [NCELL];

  genvar gi;
  generate
    for (gi = 0; gi < NCELL; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        ffpa_cell #(
          .POOL_BYTES   (POOL_BYTES),
          .HEADER_BYTES (HEADER_BYTES),
          .FIRST        (1'b1)
        ) u_cell (
          .clk        (clk),
          .rst        (rst),
          .start      (start),
          .split_any  (split_any),
          .left_pass  (start),
          .left_want  (request_size),
          .left_off   ('0),
          .left_valid (1'b0),
          .left_free  (1'b0),
          .left_size  ('0),
          .left_split (1'b0),
          .left_rest  ('0),
          .pass       (c_pass[gi]),
          .pass_want  (c_want[gi]),
          .pass_off   (c_off[gi]),
          .valid      (c_valid[gi]),
          .free       (c_free[gi]),
          .size       (c_size[gi]),
          .split      (c_split[gi]),
          .rest       (c_rest[gi]),
          .hit        (c_hit[gi]),
          .fail       (c_fail[gi]),
          .hit_offset (c_hitoff[gi])
        );
      end else begin : g_body
        ffpa_cell #(
          .POOL_BYTES   (POOL_BYTES),
          .HEADER_BYTES (HEADER_BYTES),
          .FIRST        (1'b0)
        ) u_cell (
          .clk        (clk),
          .rst        (rst),
          .start      (start),
          .split_any  (split_any),
          .left_pass  (c_pass[gi-1]),
          .left_want  (c_want[gi-1]),
          .left_off   (c_off[gi-1]),
          .left_valid (c_valid[gi-1]),
          .left_free  (c_free[gi-1]),
          .left_size  (c_size[gi-1]),
          .left_split (c_split[gi-1]),
          .left_rest  (c_rest[gi-1]),
          .pass       (c_pass[gi]),
          .pass_want  (c_want[gi]),
          .pass_off   (c_off[gi]),
          .valid      (c_valid[gi]),
          .free       (c_free[gi]),
          .size       (c_size[gi]),
          .split      (c_split[gi]),
          .rest       (c_rest[gi]),
          .hit        (c_hit[gi]),
          .fail       (c_fail[gi]),
          .hit_offset (c_hitoff[gi])
        );
      end
    end
  endgenerate

  // only one cell holds the token, so plain OR gathers its outcome
  always_comb begin
    split_any     = 1'b0;
    status.hit    = 1'b0;
    status.fail   = c_pass[NCELL-1];
    status.offset = '0;
    for (int i = 0; i < NCELL; i++) begin
      split_any     = split_any | c_split[i];
      status.hit    = status.hit | c_hit[i];
      status.fail   = status.fail | c_fail[i];
      status.offset = status.offset | (c_hit[i] ? c_hitoff[i] : '0);
    end
  end

  ffpa_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .request_size (request_size),
    .start        (start),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .granted      (granted),
    .data_offset  (data_offset)
  );

endmodule

// ===== rtl/core/ffpa_checker.sv =====
module ffpa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          granted,
  input logic [ffpa_pkg::OFFSET_W-1:0] data_offset
);

  // leave reset ready for a request
  a_ready_after_reset: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled right after reset");

  // one request at a time: a transfer closes the input
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open in the cycle after a transfer");

  // a refused request reports offset zero
  a_fail_zero_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> (data_offset == '0))
    else $error("nonzero offset on a refused request");

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(granted) && $stable(data_offset)))
    else $error("stalled result changed");

endmodule

bind first_fit_pool_allocator ffpa_checker u_ffpa_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .granted     (granted),
  .data_offset (data_offset)
);

// ===== tb/tb_first_fit_pool_allocator.sv =====
module tb_first_fit_pool_allocator;

  localparam int POOL_BYTES   = ffpa_pkg::POOL_BYTES_DEF;
  localparam int HEADER_BYTES = ffpa_pkg::HEADER_BYTES_DEF;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_ITEMS = 600;
  localparam int QUIET_ITEMS  = 100;

  typedef struct packed {
    logic                          granted;
    logic [ffpa_pkg::OFFSET_W-1:0] offset;
  } alloc_result_t;

  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          in_valid     = 1'b0;
  logic                          in_stall;
  logic [ffpa_pkg::REQ_W-1:0]    request_size = '0;
  logic                          out_valid;
  logic                          out_stall    = 1'b0;
  logic                          granted;
  logic [ffpa_pkg::OFFSET_W-1:0] data_offset;

  // one signed size per byte offset; only block starts are ever read
  logic signed [7:0] block_hdr [POOL_BYTES];
  alloc_result_t     pending_allocs [$];
  alloc_result_t     oldest_alloc;

  int errors        = 0;
  int cycles        = 0;
  int hold_left     = 0;
  bit src_idle_en   = 1'b1;
  bit sink_idle_en  = 1'b1;
  bit long_hold_req = 1'b0;

  first_fit_pool_allocator i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .request_size (request_size),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .granted      (granted),
    .data_offset  (data_offset)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // first-fit walk with split; updates the header copy on a grant
  function automatic alloc_result_t predict_alloc(input logic [ffpa_pkg::REQ_W-1:0] size);
    alloc_result_t res;
    int            want;
    int            pos;
    int            h;
    res  = '0;
    want = size;
    if (want == 0) return res;
    pos = 0;
    while (pos < POOL_BYTES) begin
      h = block_hdr[pos];
      if (h == 0) break;
      if (h >= want) begin
        if (h > HEADER_BYTES + want) begin
          block_hdr[pos + HEADER_BYTES + want] = 8'(h - want - HEADER_BYTES);
          h = want;
        end
        block_hdr[pos] = 8'(-h);
        res.granted    = 1'b1;
        res.offset     = ffpa_pkg::OFFSET_W'(pos + HEADER_BYTES);
        return res;
      end
      pos += (h < 0 ? -h : h) + HEADER_BYTES;
    end
    return res;
  endfunction

  // size of the first free block, 0 once the pool is used up
  function automatic int free_tail_bytes();
    int pos;
    int h;
    pos = 0;
    while (pos < POOL_BYTES) begin
      h = block_hdr[pos];
      if (h == 0) return 0;
      if (h > 0) return h;
      pos += -h + HEADER_BYTES;
    end
    return 0;
  endfunction

  task automatic send_request(input logic [ffpa_pkg::REQ_W-1:0] size);
    while (src_idle_en && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    request_size <= size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_allocs.push_back(predict_alloc(size));
  endtask

  // drop valid so the last transfer is not offered again
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_allocs.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall, or a long hold when asked
  always @(posedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left     = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= sink_idle_en && ($urandom_range(99) < 16);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_allocs.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer granted=%0b data_offset=%0d",
                 $time, granted, data_offset);
      end else begin
        oldest_alloc = pending_allocs.pop_front();
        if (granted !== oldest_alloc.granted) begin
          errors++;
          $display("%0t: granted expected %0b actual %0b",
                   $time, oldest_alloc.granted, granted);
        end
        if (data_offset !== oldest_alloc.offset) begin
          errors++;
          $display("%0t: data_offset expected %0d actual %0d",
                   $time, oldest_alloc.offset, data_offset);
        end
      end
    end
  end

  // zero size and sizes beyond the free space of a fresh pool
  task automatic test_rejects();
    send_request(8'd0);
    send_request(8'd255);
    send_request(8'd128);
    send_request(8'd125);
    send_request(8'd0);
  endtask

  // splits off the front, then a zero size and misses that walk over allocated blocks, then one more split
  task automatic test_splits();
    send_request(8'd1);
    send_request(8'd2);
    send_request(8'd3);
    send_request(8'd7);
    send_request(8'd0);
    send_request(8'd255);
    send_request(8'd120);
    send_request(8'd100);
    send_request(8'd10);
  endtask

  // hold the output long enough that the block stops taking requests
  task automatic test_backpressure();
    wait_drained();
    src_idle_en   = 1'b0;
    long_hold_req = 1'b1;
    send_request(8'd1);
    send_request(8'd0);
    send_request(8'd2);
    send_request(8'd200);
    send_request(8'd1);
    send_request(8'd3);
    send_request(8'd0);
    send_request(8'd4);
    src_idle_en = 1'b1;
  endtask

  // fill the pool with small blocks among zero and random sizes, end it with an exact or near fit,
  // then keep probing the full pool
  task automatic test_random_fill();
    int                         tail;
    int                         r;
    logic [ffpa_pkg::REQ_W-1:0] size;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      src_idle_en  = (i >= QUIET_ITEMS);
      sink_idle_en = (i >= QUIET_ITEMS);
      tail = free_tail_bytes();
      r    = $urandom_range(99);
      if (tail > 0 && tail <= 12)
        size = ffpa_pkg::REQ_W'(tail - $urandom_range(0, (tail > 3) ? 3 : tail - 1));
      else if (tail > 0 && r < 60)
        size = ffpa_pkg::REQ_W'($urandom_range(1, 6));
      else if (r < 70)
        size = '0;
      else
        size = ffpa_pkg::REQ_W'($urandom_range(255));
      send_request(size);
    end
  endtask

  initial begin
    for (int i = 0; i < POOL_BYTES; i++) block_hdr[i] = '0;
    block_hdr[0] = 8'(POOL_BYTES - HEADER_BYTES);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_rejects();
    test_splits();
    test_backpressure();
    test_random_fill();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
